// ----- rtl/core/lssc_pkg.sv -----
// Shared types and constants for the line sensor steering correction block.
// No dependencies; every other file of the block imports this package.
package lssc_pkg;

   // Bar size and fixed field widths
   localparam int LSSC_SENSOR_COUNT = 16;
   localparam int READING_W         = 8;
   localparam int INDEX_OUT_W       = 4;
   localparam int CORR_W            = 9;
   localparam int STATUS_W          = 2;
   localparam int EXP_W             = 3;
   localparam int GAIN_W            = 16;
   localparam int CENTRE_W          = 4;
   localparam int POWER_W           = 16;
   localparam int PROD_W            = 32;

   // Reading value that marks the line
   localparam logic [READING_W-1:0] ON_LINE_CODE = 8'd1;

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_EXPONENT = 2'd0,
      REG_GAIN     = 2'd1,
      REG_CENTRE   = 2'd2,
      REG_FINE     = 2'd3
   } lssc_reg_type;

   localparam logic [EXP_W-1:0]    EXPONENT_RST = 3'd2;
   localparam logic [GAIN_W-1:0]   GAIN_RST     = 16'd100;
   localparam logic [CENTRE_W-1:0] CENTRE_RST   = 4'd7;

   // Track status codes
   localparam logic [STATUS_W-1:0] STATUS_NORMAL  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EDGE    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_LINE = 2'd2;

   // Saturation and unscaling by 10 or 100.
   // A product at or above 181 * divisor saturates; below that it fits 15 bits
   // and a reciprocal multiply gives the exact quotient.
   localparam int              CORR_LIMIT   = 180;
   localparam logic [PROD_W-1:0] SAT_COARSE = 32'd1810;
   localparam logic [PROD_W-1:0] SAT_FINE   = 32'd18100;
   localparam int              SMALL_W      = 15;
   localparam int              RECIP_W      = 16;
   localparam logic [RECIP_W-1:0] RECIP_COARSE = 16'd52429;  // 2^19 / 10
   localparam logic [RECIP_W-1:0] RECIP_FINE   = 16'd41944;  // 2^22 / 100
   localparam int              SHIFT_COARSE = 19;
   localparam int              SHIFT_FINE   = 22;
   localparam int              MAG_OUT_W    = 8;

   // Configuration seen by the datapath
   typedef struct packed {
      logic [EXP_W-1:0]    exponent;
      logic [GAIN_W-1:0]   gain;
      logic [CENTRE_W-1:0] centre;
      logic                fine;
   } lssc_cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic in_ready;
      logic setup;
      logic power_step;
      logic product;
      logic scale;
      logic load_out;
   } lssc_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic in_valid;
      logic in_last;
      logic pow_done;
      logic out_free;
   } lssc_stat_type;

endpackage

// ----- rtl/core/lssc_if.sv -----
// Valid/ready channel interfaces for sensor readings and correction results.
// Depends on lssc_pkg for field widths.
interface lssc_req_if
   import lssc_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [READING_W-1:0] reading;
   logic                 frame_start;

   modport source (output valid, output reading, output frame_start, input ready);
   modport sink   (input valid, input reading, input frame_start, output ready);
endinterface

interface lssc_rsp_if
   import lssc_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic signed [CORR_W-1:0] correction;
   logic [STATUS_W-1:0]      track_status;
   logic [INDEX_OUT_W-1:0]   line_midpoint;
   logic [INDEX_OUT_W-1:0]   run_first;
   logic [INDEX_OUT_W-1:0]   run_last;

   modport source (output valid, output correction, output track_status,
                   output line_midpoint, output run_first, output run_last,
                   input ready);
   modport sink   (input valid, input correction, input track_status,
                   input line_midpoint, input run_first, input run_last,
                   output ready);
endinterface

// ----- rtl/core/lssc_csr.sv -----
// Configuration registers behind an APB-style write/read port.
// Depends on lssc_pkg for register indexes, widths and reset values.
module lssc_csr
   import lssc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output lssc_cfg_type          cfg
);

   lssc_cfg_type cfg_ff, cfg_in;
   logic         wr_en;
   lssc_reg_type reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = lssc_reg_type'(paddr[CSR_IDX_W+1:2]);
   assign cfg     = cfg_ff;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_EXPONENT: cfg_in.exponent = pwdata[EXP_W-1:0];
            REG_GAIN:     cfg_in.gain     = pwdata[GAIN_W-1:0];
            REG_CENTRE:   cfg_in.centre   = pwdata[CENTRE_W-1:0];
            REG_FINE:     cfg_in.fine     = pwdata[0];
            default:      cfg_in          = cfg_ff;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (reg_sel)
         REG_EXPONENT: prdata = CSR_DATA_W'(cfg_ff.exponent);
         REG_GAIN:     prdata = CSR_DATA_W'(cfg_ff.gain);
         REG_CENTRE:   prdata = CSR_DATA_W'(cfg_ff.centre);
         REG_FINE:     prdata = CSR_DATA_W'(cfg_ff.fine);
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.exponent <= EXPONENT_RST;
         cfg_ff.gain     <= GAIN_RST;
         cfg_ff.centre   <= CENTRE_RST;
         cfg_ff.fine     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/core/lssc_ctrl.sv -----
// Sequencer for one frame's correction: setup, power loop, gain, unscale, output.
// Depends on lssc_pkg for the command and status structs.
module lssc_ctrl
   import lssc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  lssc_stat_type stat,
   output lssc_cmd_type  cmd
);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_SETUP   = 6'b000010,
      ST_POWER   = 6'b000100,
      ST_PRODUCT = 6'b001000,
      ST_SCALE   = 6'b010000,
      ST_DONE    = 6'b100000
   } lssc_state_type;

   lssc_state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.in_ready = 1'b1;
            if (stat.in_valid && stat.in_last) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_POWER;
         end
         ST_POWER: begin
            if (stat.pow_done) begin
               state_in = ST_PRODUCT;
            end else begin
               cmd.power_step = 1'b1;
            end
         end
         ST_PRODUCT: begin
            cmd.product = 1'b1;
            state_in    = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   // A frame's last item always starts the sequence
   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.in_ready && stat.in_valid && stat.in_last |=> state_ff == ST_SETUP)
      else $error("last item did not start the sequence");

   // The power loop leaves once the count runs out
   a_power_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POWER && stat.pow_done |=> state_ff == ST_PRODUCT)
      else $error("power loop did not exit");

   // No item is taken while a frame is being finished
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !cmd.in_ready)
      else $error("item taken while busy");
`endif

endmodule

// ----- rtl/core/lssc_datapath.sv -----
// Run tracking, power loop, gain multiply, unscale and result register.
// Depends on lssc_pkg and the channel interfaces in lssc_if.
module lssc_datapath
   import lssc_pkg::*;
#(
   parameter int SENSOR_COUNT = LSSC_SENSOR_COUNT
) (
   input  logic          clock,
   input  logic          reset,
   input  lssc_cfg_type  cfg,
   input  lssc_cmd_type  cmd,
   output lssc_stat_type stat,
   lssc_req_if.sink      req,
   lssc_rsp_if.source    rsp
);

   localparam int IDX_W = $clog2(SENSOR_COUNT);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SENSOR_COUNT - 1);
   localparam int MAG_W = (IDX_W > CENTRE_W) ? IDX_W : CENTRE_W;
   localparam int ERR_W = MAG_W + 1;

   // Run tracking state
   logic [IDX_W-1:0] sens_idx_ff, sens_idx_in;
   logic             in_run_ff, in_run_in;
   logic [IDX_W-1:0] cur_start_ff, cur_start_in;
   logic [IDX_W-1:0] cur_end_ff, cur_end_in;
   logic [IDX_W-1:0] best_start_ff, best_start_in;
   logic [IDX_W-1:0] best_end_ff, best_end_in;
   logic [IDX_W-1:0] best_width_ff, best_width_in;
   logic [IDX_W-1:0] fin_start_ff, fin_start_in;
   logic [IDX_W-1:0] fin_end_ff, fin_end_in;

   logic [IDX_W-1:0] idx;
   logic             idx_first;
   logic             idx_last;
   logic             on_line;
   logic             take;
   logic [IDX_W-1:0] run_w;
   logic [IDX_W-1:0] end_w;

   // Frame finish state
   logic [IDX_W-1:0]    mid_ff;
   logic [STATUS_W-1:0] status_ff;
   logic                neg_ff;
   logic                no_line_ff;
   logic [MAG_W-1:0]    mag_ff;
   logic [POWER_W-1:0]  powered_ff;
   logic [EXP_W-1:0]    cnt_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic                sat_ff;
   logic [SMALL_W+RECIP_W-1:0] scaled_ff;

   logic [IDX_W:0]      mid_sum;
   logic [IDX_W-1:0]    mid;
   logic signed [ERR_W-1:0] err;
   logic [ERR_W-1:0]    err_abs;
   logic [POWER_W+MAG_W-1:0] pow_full;
   logic [PROD_W-1:0]   sat_limit;
   logic [RECIP_W-1:0]  recip;
   logic [SMALL_W+RECIP_W-1:0] quot_full;
   logic [MAG_OUT_W-1:0] corr_mag;
   logic [CORR_W-1:0]   corr_pos;

   // Result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [CORR_W-1:0] corr_ff;
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic [IDX_W-1:0]         rsp_mid_ff;
   logic [IDX_W-1:0]         rsp_first_ff;
   logic [IDX_W-1:0]         rsp_last_ff;
   logic [IDX_W+INDEX_OUT_W-1:0] mid_ext;
   logic [IDX_W+INDEX_OUT_W-1:0] first_ext;
   logic [IDX_W+INDEX_OUT_W-1:0] last_ext;

   assign idx       = req.frame_start ? '0 : sens_idx_ff;
   assign idx_first = (idx == '0);
   assign idx_last  = (idx == LAST_IDX);
   assign on_line   = (req.reading == ON_LINE_CODE);
   assign take      = req.valid & cmd.in_ready;
   assign req.ready = cmd.in_ready;

   assign stat.in_valid = req.valid;
   assign stat.in_last  = idx_last;
   assign stat.pow_done = (cnt_ff == '0);
   assign stat.out_free = ~rsp_valid_ff | rsp.ready;

   // Update the run tracking for one reading; index 0 starts from a clear state
   always_comb begin
      in_run_in     = idx_first ? 1'b0 : in_run_ff;
      cur_start_in  = idx_first ? '0 : cur_start_ff;
      cur_end_in    = idx_first ? '0 : cur_end_ff;
      best_start_in = idx_first ? '0 : best_start_ff;
      best_end_in   = idx_first ? '0 : best_end_ff;
      best_width_in = idx_first ? '0 : best_width_ff;
      run_w         = cur_end_in - cur_start_in;
      end_w         = '0;

      if (on_line) begin
         if (in_run_in) begin
            cur_end_in = idx;
         end else begin
            cur_start_in = idx;
            cur_end_in   = idx;
            in_run_in    = 1'b1;
         end
      end else if (in_run_in) begin
         // close the run at the first off reading; ties go to the later run
         in_run_in = 1'b0;
         if (run_w >= best_width_in) begin
            best_width_in = run_w;
            best_start_in = cur_start_in;
            best_end_in   = cur_end_in;
         end
      end

      // a run still open at the bar's end closes there
      if (idx_last && in_run_in) begin
         cur_end_in = LAST_IDX;
         in_run_in  = 1'b0;
         end_w      = LAST_IDX - cur_start_in;
         if (end_w >= best_width_in) begin
            best_width_in = end_w;
            best_start_in = cur_start_in;
            best_end_in   = LAST_IDX;
         end
      end

      sens_idx_in  = idx_last ? '0 : idx + IDX_W'(1);
      fin_start_in = best_start_in;
      fin_end_in   = best_end_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sens_idx_ff   <= '0;
         in_run_ff     <= 1'b0;
         cur_start_ff  <= '0;
         cur_end_ff    <= '0;
         best_start_ff <= '0;
         best_end_ff   <= '0;
         best_width_ff <= '0;
      end else if (take) begin
         sens_idx_ff   <= sens_idx_in;
         in_run_ff     <= in_run_in;
         cur_start_ff  <= cur_start_in;
         cur_end_ff    <= cur_end_in;
         best_start_ff <= best_start_in;
         best_end_ff   <= best_end_in;
         best_width_ff <= best_width_in;
      end
   end

   // Hold the frame's widest run for the finishing steps
   always_ff @(posedge clock) begin
      if (take && idx_last) begin
         fin_start_ff <= fin_start_in;
         fin_end_ff   <= fin_end_in;
      end
   end

   // Midpoint, signed error and status
   assign mid_sum = {1'b0, fin_start_ff} + {1'b0, fin_end_ff};
   assign mid     = mid_sum[IDX_W:1];
   assign err     = $signed(ERR_W'(mid)) - $signed(ERR_W'(cfg.centre));
   assign err_abs = err[ERR_W-1] ? (~err + ERR_W'(1)) : err;

   // Power loop: one multiply per cycle, wrapping to 16 bits
   assign pow_full = powered_ff * mag_ff;

   // Unscale: saturation compare and reciprocal multiply
   assign sat_limit = cfg.fine ? SAT_FINE : SAT_COARSE;
   assign recip     = cfg.fine ? RECIP_FINE : RECIP_COARSE;
   assign quot_full = cfg.fine ? (scaled_ff >> SHIFT_FINE) : (scaled_ff >> SHIFT_COARSE);
   assign corr_mag  = sat_ff ? MAG_OUT_W'(CORR_LIMIT) : quot_full[MAG_OUT_W-1:0];
   assign corr_pos  = {1'b0, corr_mag};

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         mid_ff     <= mid;
         neg_ff     <= ~(err > 0);
         no_line_ff <= (mid == '0);
         mag_ff     <= err_abs[MAG_W-1:0];
         powered_ff <= POWER_W'(1);
         if (mid == '0) begin
            status_ff <= STATUS_NO_LINE;
         end else if (fin_start_ff == '0 || fin_end_ff == LAST_IDX) begin
            status_ff <= STATUS_EDGE;
         end else begin
            status_ff <= STATUS_NORMAL;
         end
      end else if (cmd.power_step) begin
         powered_ff <= pow_full[POWER_W-1:0];
      end
      if (cmd.product) prod_ff <= cfg.gain * powered_ff;
      if (cmd.scale) begin
         sat_ff    <= (prod_ff >= sat_limit);
         scaled_ff <= prod_ff[SMALL_W-1:0] * recip;
      end
   end

   // Exponent countdown
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.setup) begin
         cnt_ff <= cfg.exponent;
      end else if (cmd.power_step) begin
         cnt_ff <= cnt_ff - EXP_W'(1);
      end
   end

   // Result register: hold until taken
   assign rsp_valid_in = cmd.load_out ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         if (no_line_ff) begin
            corr_ff <= '0;
         end else if (neg_ff) begin
            corr_ff <= $signed(~corr_pos + CORR_W'(1));
         end else begin
            corr_ff <= $signed(corr_pos);
         end
         rsp_status_ff <= status_ff;
         rsp_mid_ff    <= mid_ff;
         rsp_first_ff  <= fin_start_ff;
         rsp_last_ff   <= fin_end_ff;
      end
   end

   // Index outputs keep their low bits
   assign mid_ext   = {{INDEX_OUT_W{1'b0}}, rsp_mid_ff};
   assign first_ext = {{INDEX_OUT_W{1'b0}}, rsp_first_ff};
   assign last_ext  = {{INDEX_OUT_W{1'b0}}, rsp_last_ff};

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.correction    = corr_ff;
   assign rsp.track_status  = rsp_status_ff;
   assign rsp.line_midpoint = mid_ext[INDEX_OUT_W-1:0];
   assign rsp.run_first     = first_ext[INDEX_OUT_W-1:0];
   assign rsp.run_last      = last_ext[INDEX_OUT_W-1:0];

`ifndef ASSERT_OFF
   // A new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> stat.out_free)
      else $error("result overwritten");

   // Correction stays within the clamp
   a_corr_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.correction <= $signed(CORR_W'(CORR_LIMIT)))
                 && (rsp.correction >= -$signed(CORR_W'(CORR_LIMIT))))
      else $error("correction outside clamp");

   // No line means no correction
   a_no_line_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.track_status == STATUS_NO_LINE |-> rsp.correction == '0)
      else $error("nonzero correction with no line");
`endif

endmodule

// ----- rtl/core/line_sensor_steering_correction.sv -----
// Line sensor steering correction, top level.
// Readings other than a frame's last are taken one per cycle while the sequencer is idle.
// After the last reading the sequencer runs setup, the power loop, product and scale, and
// the result register loads once it is free. The power loop reuses one 16-bit multiplier
// once per exponent step. No reading is taken while a frame is being finished.
// Reset: synchronous, active high; clears tracking, sequencer, result valid; loads config.
module line_sensor_steering_correction
   import lssc_pkg::*;
#(
   parameter int SENSOR_COUNT = LSSC_SENSOR_COUNT
) (
   input  logic                  clock,
   input  logic                  reset,
   lssc_req_if.sink              req_chan,
   lssc_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   lssc_cfg_type  cfg;
   lssc_cmd_type  cmd;
   lssc_stat_type stat;

   // Configuration registers
   lssc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Sequencer
   lssc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   // Tracking and arithmetic
   lssc_datapath #(
      .SENSOR_COUNT (SENSOR_COUNT)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .cmd   (cmd),
      .stat  (stat),
      .req   (req_chan),
      .rsp   (rsp_chan)
   );

endmodule

// ----- verif/tb_line_sensor_steering_correction.sv -----
`timescale 1ns / 1ps
// Testbench for line_sensor_steering_correction: drives sensor frames and register
// settings, predicts each frame's steering correction and checks every result item.
// Depends on lssc_pkg and the lssc_req_if / lssc_rsp_if channel interfaces.

typedef struct packed {
   logic signed [lssc_pkg::CORR_W-1:0] correction;
   logic [lssc_pkg::STATUS_W-1:0]      track_status;
   logic [lssc_pkg::INDEX_OUT_W-1:0]   line_midpoint;
   logic [lssc_pkg::INDEX_OUT_W-1:0]   run_first;
   logic [lssc_pkg::INDEX_OUT_W-1:0]   run_last;
} steer_result_type;

// Tracks line runs per frame and holds the corrections still owed by the block
class steering_scoreboard;
   localparam logic [3:0] LAST_INDEX = 4'(lssc_pkg::LSSC_SENSOR_COUNT - 1);

   logic [lssc_pkg::EXP_W-1:0]    exponent;
   logic [lssc_pkg::GAIN_W-1:0]   gain;
   logic [lssc_pkg::CENTRE_W-1:0] centre;
   logic                          fine;

   logic [3:0] bar_pos;
   bit         in_line;
   logic [3:0] run_start;
   logic [3:0] run_end;
   logic [3:0] widest_start;
   logic [3:0] widest_end;
   logic [3:0] widest_span;

   steer_result_type expected_corrections[$];
   int               mismatches = 0;

   function new();
      exponent = lssc_pkg::EXPONENT_RST;
      gain     = lssc_pkg::GAIN_RST;
      centre   = lssc_pkg::CENTRE_RST;
      fine     = 1'b0;
      bar_pos  = '0;
      clear_runs();
   endfunction

   function void set_register(lssc_pkg::lssc_reg_type index, logic [31:0] value);
      case (index)
         lssc_pkg::REG_EXPONENT: exponent = value[lssc_pkg::EXP_W-1:0];
         lssc_pkg::REG_GAIN:     gain     = value[lssc_pkg::GAIN_W-1:0];
         lssc_pkg::REG_CENTRE:   centre   = value[lssc_pkg::CENTRE_W-1:0];
         lssc_pkg::REG_FINE:     fine     = value[0];
         default: ;
      endcase
   endfunction

   function void clear_runs();
      in_line      = 1'b0;
      run_start    = '0;
      run_end      = '0;
      widest_start = '0;
      widest_end   = '0;
      widest_span  = '0;
   endfunction

   // Close the open run; a tie goes to the later run
   function void close_run();
      logic [3:0] span;
      span    = run_end - run_start;
      in_line = 1'b0;
      if (span >= widest_span) begin
         widest_span  = span;
         widest_start = run_start;
         widest_end   = run_end;
      end
   endfunction

   function int pending();
      return expected_corrections.size();
   endfunction

   // Advance the run tracker by one accepted reading; at the frame's end
   // work out the correction the block owes
   function void note_reading(logic [7:0] reading, logic frame_start);
      logic [3:0]  idx;
      logic [4:0]  index_sum;
      logic [15:0] magnitude;
      logic [15:0] powered;
      longint      product;
      int          error;
      int          step;
      steer_result_type res;
      if (frame_start) bar_pos = '0;
      if (bar_pos == '0) clear_runs();
      idx = bar_pos;
      if (reading == lssc_pkg::ON_LINE_CODE) begin
         if (in_line) begin
            run_end = idx;
         end else begin
            run_start = idx;
            run_end   = idx;
            in_line   = 1'b1;
         end
      end else if (in_line) begin
         close_run();
      end
      if (idx != LAST_INDEX) begin
         bar_pos = idx + 4'd1;
         return;
      end
      if (in_line) begin
         run_end = LAST_INDEX;
         close_run();
      end

      index_sum         = {1'b0, widest_start} + {1'b0, widest_end};
      res.line_midpoint = index_sum[4:1];
      res.run_first     = widest_start;
      res.run_last      = widest_end;
      res.correction    = '0;
      res.track_status  = (widest_start == '0 || widest_end == LAST_INDEX) ?
                          lssc_pkg::STATUS_EDGE : lssc_pkg::STATUS_NORMAL;
      if (res.line_midpoint == '0) begin
         res.track_status = lssc_pkg::STATUS_NO_LINE;
      end else begin
         // Zero error counts as negative
         error     = int'(res.line_midpoint) - int'(centre);
         magnitude = 16'(error < 0 ? -error : error);
         powered   = 16'd1;
         for (step = 0; step < int'(exponent); step++) powered = powered * magnitude;
         product = longint'(gain) * longint'(powered);
         if (error <= 0) product = -product;
         product = product / longint'(fine ? 100 : 10);
         if (product > lssc_pkg::CORR_LIMIT) product = lssc_pkg::CORR_LIMIT;
         if (product < -lssc_pkg::CORR_LIMIT) product = -lssc_pkg::CORR_LIMIT;
         res.correction = 9'(product);
      end
      expected_corrections.push_back(res);
      bar_pos = '0;
      clear_runs();
   endfunction

   task report(string field, int got_value, int want_value);
      mismatches++;
      if (mismatches <= 100)
         $display("mismatch in %s: got %0d, expected %0d", field, got_value, want_value);
   endtask

   task check_result(steer_result_type got);
      steer_result_type want;
      if (expected_corrections.size() == 0) begin
         report("unexpected result, correction", $signed(got.correction), 0);
         return;
      end
      want = expected_corrections.pop_front();
      if (got.correction !== want.correction)
         report("correction", $signed(got.correction), $signed(want.correction));
      if (got.track_status !== want.track_status)
         report("track_status", got.track_status, want.track_status);
      if (got.line_midpoint !== want.line_midpoint)
         report("line_midpoint", got.line_midpoint, want.line_midpoint);
      if (got.run_first !== want.run_first)
         report("run_first", got.run_first, want.run_first);
      if (got.run_last !== want.run_last)
         report("run_last", got.run_last, want.run_last);
   endtask
endclass

module tb_line_sensor_steering_correction;
   import lssc_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 24;
   localparam int PHASE_ITEMS   = 165;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   bit send_gaps  = 1'b1;
   bit rsp_stalls = 1'b1;
   int cycle_count = 0;

   steering_scoreboard sb = new();

   lssc_req_if req_chan ();
   lssc_rsp_if rsp_chan ();

   line_sensor_steering_correction dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog
   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Result side: check each accepted item, then stall at random
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready)
            sb.check_result(steer_result_type'{rsp_chan.correction, rsp_chan.track_status,
                                               rsp_chan.line_midpoint, rsp_chan.run_first,
                                               rsp_chan.run_last});
         rsp_chan.ready <= !rsp_stalls || ($urandom_range(99) >= 15);
      end
   end

   // Offer one reading, idling first at random, and note it once accepted
   task automatic send_reading(input logic [READING_W-1:0] value, input logic marked);
      while (send_gaps && $urandom_range(99) < 15) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.reading     <= value;
      req_chan.frame_start <= marked;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_reading(value, marked);
   endtask

   // Send count readings of a frame whose line shape is drawn at random
   task automatic send_frame(input bit marked, input int count);
      logic [15:0]          line_mask;
      logic [READING_W-1:0] value;
      int                   first;
      int                   span;
      int                   i;
      first = $urandom_range(15);
      span  = $urandom_range(1, 6);
      case ($urandom_range(9))
         0:       line_mask = '0;
         1:       line_mask = '1;
         8, 9:    line_mask = 16'($urandom);
         default: begin
            line_mask = 16'(((32'd1 << span) - 1) << first);
            if ($urandom_range(2) == 0) line_mask[$urandom_range(15)] = 1'b1;
         end
      endcase
      for (i = 0; i < count; i++) begin
         if (line_mask[i]) begin
            value = ON_LINE_CODE;
         end else begin
            case ($urandom_range(3))
               0:       value = '0;
               1:       value = '1;
               default: value = READING_W'($urandom);
            endcase
         end
         send_reading(value, marked && i == 0);
      end
   endtask

   // Drop valid and hold until every owed result has come back
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Setup then access; psel stays up between back-to-back writes
   task automatic csr_write(input lssc_reg_type index, input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_register(index, value);
   endtask

   task automatic apply_config(input logic [EXP_W-1:0] exponent,
                               input logic [GAIN_W-1:0] gain_value,
                               input logic [CENTRE_W-1:0] centre,
                               input logic fine);
      csr_write(REG_EXPONENT, CSR_DATA_W'(exponent));
      csr_write(REG_GAIN, CSR_DATA_W'(gain_value));
      csr_write(REG_CENTRE, CSR_DATA_W'(centre));
      csr_write(REG_FINE, CSR_DATA_W'(fine));
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   initial begin
      logic [READING_W-1:0] pattern [16];
      int i;
      int sent;
      int phase;
      int shape;
      int count;
      bit marked;
      bit paused;
      req_chan.valid       <= 1'b0;
      req_chan.reading     <= '0;
      req_chan.frame_start <= 1'b0;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= '0;
      pwdata  <= '0;
      reset   <= 1'b1;
      paused = 1'b0;
      // Two runs of equal width (later one wins), a lone dot, off-line bytes
      pattern = '{8'hFF, 8'h01, 8'h01, 8'h00, 8'h02, 8'h01, 8'h01, 8'h80,
                  8'h00, 8'h01, 8'h7F, 8'h00, 8'h00, 8'h00, 8'hFE, 8'h00};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frame under reset settings
      for (i = 0; i < 16; i++) send_reading(pattern[i], i == 0);
      // Broken frame: frame start mid-frame restarts the index
      for (i = 0; i < 8; i++) send_reading(ON_LINE_CODE, i == 0 || i == 4);

      for (phase = 0; phase < 8; phase++) begin
         // Reconfigure only while nothing is in flight
         case (phase)
            0: ;
            1: apply_config(3'd0, 16'hFFFF, 4'd0, 1'b0);
            2: apply_config(3'd7, 16'd1, 4'd15, 1'b1);
            3: apply_config(3'd1, 16'd100, 4'd7, 1'b1);
            4: apply_config(3'd3, 16'd250, 4'd5, 1'b0);
            5: apply_config(3'd0, GAIN_W'($urandom_range(3000)),
                            CENTRE_W'($urandom_range(15)), 1'($urandom_range(1)));
            6: apply_config(EXP_W'($urandom_range(1, 4)), 16'd0,
                            CENTRE_W'($urandom_range(15)), 1'($urandom_range(1)));
            default: apply_config(EXP_W'($urandom_range(7)),
                                  $urandom_range(1) ? GAIN_W'($urandom) :
                                                      GAIN_W'($urandom_range(400)),
                                  CENTRE_W'($urandom_range(15)), 1'($urandom_range(1)));
         endcase
         // One long stretch with no idling on either side
         send_gaps  = (phase != 4);
         rsp_stalls = (phase != 4);

         sent = 0;
         while (sent < PHASE_ITEMS) begin
            shape = $urandom_range(19);
            if (shape < 15) begin
               marked = 1'b1;
               count  = 16;
            end else if (shape < 18) begin
               marked = 1'b0;
               count  = 16;
            end else begin
               marked = 1'b1;
               count  = $urandom_range(1, 15);
            end
            send_frame(marked, count);
            sent += count;
            // Hold the sender once until every result is back
            if (phase == 2 && !paused && sent >= PHASE_ITEMS / 2) begin
               wait_for_results();
               paused = 1'b1;
            end
         end
         wait_for_results();
         repeat (SETTLE_CYCLES) @(posedge clock);
      end

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
